@@ rtl/core/three_rotor_reflector_cipher_defines.svh @@
// Assertion macros shared by the cipher RTL.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef THREE_ROTOR_REFLECTOR_CIPHER_DEFINES_SVH
`define THREE_ROTOR_REFLECTOR_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
`define TRRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TRRC_NEVER(lbl, cond, msg) \
  `TRRC_ASSERT(lbl, !(cond), msg)
`else
`define TRRC_ASSERT(lbl, prop, msg)
`define TRRC_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/core/trrc_pkg.sv @@
`default_nettype none

package trrc_pkg;

  localparam int LETTERS     = 26;
  localparam int TURN_RIGHT  = 17;  // R
  localparam int TURN_MIDDLE = 22;  // W
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_LETTER = 1'b0;
  localparam logic KIND_RELOAD = 1'b1;

  localparam logic [1:0] REG_LEFT_START   = 2'd0;
  localparam logic [1:0] REG_MIDDLE_START = 2'd1;
  localparam logic [1:0] REG_RIGHT_START  = 2'd2;

  typedef logic [4:0] letter_t;

  typedef struct packed {
    letter_t left;
    letter_t middle;
    letter_t right;
  } pos_t;

  typedef struct packed {
    letter_t letter;
    pos_t    pos;
  } job_t;

  localparam letter_t WIRE_RIGHT [LETTERS] = '{
    5'd9, 5'd0, 5'd12, 5'd19, 5'd20, 5'd3, 5'd5, 5'd17, 5'd21, 5'd4, 5'd13, 5'd22, 5'd1,
    5'd2, 5'd11, 5'd7, 5'd14, 5'd23, 5'd24, 5'd16, 5'd8, 5'd15, 5'd10, 5'd25, 5'd6, 5'd18};
  localparam letter_t WIRE_MIDDLE [LETTERS] = '{
    5'd17, 5'd22, 5'd14, 5'd15, 5'd4, 5'd9, 5'd19, 5'd11, 5'd24, 5'd1, 5'd2, 5'd13, 5'd16,
    5'd6, 5'd0, 5'd8, 5'd7, 5'd21, 5'd12, 5'd18, 5'd5, 5'd23, 5'd10, 5'd3, 5'd25, 5'd20};
  localparam letter_t WIRE_LEFT [LETTERS] = '{
    5'd19, 5'd9, 5'd10, 5'd0, 5'd14, 5'd25, 5'd20, 5'd12, 5'd5, 5'd7, 5'd8, 5'd6, 5'd13,
    5'd21, 5'd2, 5'd18, 5'd11, 5'd24, 5'd1, 5'd3, 5'd15, 5'd16, 5'd4, 5'd22, 5'd17, 5'd23};
  localparam letter_t WIRE_REFL [LETTERS] = '{
    5'd16, 5'd24, 5'd7, 5'd14, 5'd6, 5'd13, 5'd4, 5'd2, 5'd21, 5'd15, 5'd20, 5'd25, 5'd19,
    5'd5, 5'd3, 5'd9, 5'd0, 5'd23, 5'd22, 5'd12, 5'd10, 5'd8, 5'd18, 5'd17, 5'd1, 5'd11};

  // Inverse wirings for the return path.
  localparam letter_t INV_RIGHT [LETTERS] = '{
    5'd1, 5'd12, 5'd13, 5'd5, 5'd9, 5'd6, 5'd24, 5'd15, 5'd20, 5'd0, 5'd22, 5'd14, 5'd2,
    5'd10, 5'd16, 5'd21, 5'd19, 5'd7, 5'd25, 5'd3, 5'd4, 5'd8, 5'd11, 5'd17, 5'd18, 5'd23};
  localparam letter_t INV_MIDDLE [LETTERS] = '{
    5'd14, 5'd9, 5'd10, 5'd23, 5'd4, 5'd20, 5'd13, 5'd16, 5'd15, 5'd5, 5'd22, 5'd7, 5'd18,
    5'd11, 5'd2, 5'd3, 5'd12, 5'd0, 5'd19, 5'd6, 5'd25, 5'd17, 5'd1, 5'd21, 5'd8, 5'd24};
  localparam letter_t INV_LEFT [LETTERS] = '{
    5'd3, 5'd18, 5'd14, 5'd19, 5'd22, 5'd8, 5'd11, 5'd9, 5'd10, 5'd1, 5'd2, 5'd16, 5'd7,
    5'd12, 5'd4, 5'd20, 5'd21, 5'd24, 5'd15, 5'd0, 5'd6, 5'd13, 5'd23, 5'd25, 5'd17, 5'd5};

  // Reduce a value below three times the alphabet size.
  function automatic letter_t mod26(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'(2 * LETTERS)) begin
      r = r - 6'(2 * LETTERS);
    end else if (r >= 6'(LETTERS)) begin
      r = r - 6'(LETTERS);
    end
    return r[4:0];
  endfunction

  function automatic letter_t add26(input letter_t x, input letter_t p);
    return mod26({1'b0, x} + {1'b0, p});
  endfunction

  // Both operands below 26; wraps mod 32 in the intermediate, result stays below 26.
  function automatic letter_t sub26(input letter_t k, input letter_t p);
    return (k >= p) ? letter_t'(k - p) : letter_t'(k + 5'(LETTERS) - p);
  endfunction

  function automatic letter_t inc26(input letter_t p);
    return (p == 5'(LETTERS - 1)) ? '0 : letter_t'(p + 5'd1);
  endfunction

  function automatic letter_t fold26(input letter_t v);
    return (v >= 5'(LETTERS)) ? letter_t'(v - 5'(LETTERS)) : v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/trrc_fifo.sv @@
`default_nettype none
`include "three_rotor_reflector_cipher_defines.svh"

module trrc_fifo #(
  parameter int DEPTH = trrc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire trrc_pkg::job_t wr_data,
  output      logic          full,
  input  wire logic          rd_en,
  output      trrc_pkg::job_t rd_data,
  output      logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trrc_pkg::job_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      count <= CW'(count + CW'(wr_en) - CW'(rd_en));
    end
  end

  `TRRC_NEVER(fifo_count_bound, count > CW'(DEPTH), "queue count above depth")

endmodule

`default_nettype wire

@@ rtl/core/trrc_front.sv @@
`default_nettype none
`include "three_rotor_reflector_cipher_defines.svh"

module trrc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire trrc_pkg::pos_t  start,
  input  wire logic            push,
  input  wire logic            kind,
  input  wire trrc_pkg::letter_t letter_in,
  input  wire logic            q_full,
  output      logic            q_wr,
  output      trrc_pkg::job_t  q_data
);

  trrc_pkg::pos_t pos;
  trrc_pkg::pos_t pos_next;
  trrc_pkg::pos_t stepped;
  logic           accept;

  assign accept = push && !q_full;

  // Right rotor always steps; carry to the middle at R, to the left at W.
  always_comb begin
    stepped       = pos;
    stepped.right = trrc_pkg::inc26(pos.right);
    if (stepped.right == 5'(trrc_pkg::TURN_RIGHT)) begin
      stepped.middle = trrc_pkg::inc26(pos.middle);
      if (stepped.middle == 5'(trrc_pkg::TURN_MIDDLE)) begin
        stepped.left = trrc_pkg::inc26(pos.left);
      end
    end
  end

  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (kind == trrc_pkg::KIND_RELOAD) begin
        pos_next.left   = trrc_pkg::fold26(start.left);
        pos_next.middle = trrc_pkg::fold26(start.middle);
        pos_next.right  = trrc_pkg::fold26(start.right);
      end else begin
        pos_next = stepped;
      end
    end
  end

  assign q_wr          = accept && (kind == trrc_pkg::KIND_LETTER);
  assign q_data.letter = letter_in;
  assign q_data.pos    = stepped;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  `TRRC_NEVER(front_pos_range, (pos.right >= 5'(trrc_pkg::LETTERS)) || (pos.middle >= 5'(trrc_pkg::LETTERS)) || (pos.left >= 5'(trrc_pkg::LETTERS)), "rotor position out of range")
  `TRRC_ASSERT(front_right_steps, q_wr |=> (pos.right == trrc_pkg::inc26($past(pos.right))), "right rotor did not step")
  `TRRC_ASSERT(front_left_hold, (q_wr && (stepped.middle != 5'(trrc_pkg::TURN_MIDDLE))) |=> (pos.left == $past(pos.left)), "left rotor stepped without carry")

endmodule

`default_nettype wire

@@ rtl/core/trrc_back.sv @@
`default_nettype none
`include "three_rotor_reflector_cipher_defines.svh"

module trrc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire trrc_pkg::job_t    q_data,
  output      logic              q_rd,
  output      logic              empty,
  input  wire logic              pop,
  output      trrc_pkg::letter_t letter_out
);

  logic              s1_valid;
  trrc_pkg::letter_t s1_refl;
  trrc_pkg::pos_t    s1_pos;
  logic              out_valid;
  logic              out_free;
  logic              s1_free;
  trrc_pkg::letter_t fwd_r;
  trrc_pkg::letter_t fwd_m;
  trrc_pkg::letter_t fwd_l;
  trrc_pkg::letter_t refl;
  trrc_pkg::letter_t bwd_l;
  trrc_pkg::letter_t bwd_m;
  trrc_pkg::letter_t bwd_r;

  assign out_free = !out_valid || pop;
  assign s1_free  = !s1_valid || out_free;
  assign q_rd     = !q_empty && s1_free;
  assign empty    = !out_valid;

  // Forward path and reflector.
  assign fwd_r = trrc_pkg::WIRE_RIGHT[trrc_pkg::add26(q_data.letter, q_data.pos.right)];
  assign fwd_m = trrc_pkg::WIRE_MIDDLE[trrc_pkg::add26(fwd_r, q_data.pos.middle)];
  assign fwd_l = trrc_pkg::WIRE_LEFT[trrc_pkg::add26(fwd_m, q_data.pos.left)];
  assign refl  = trrc_pkg::WIRE_REFL[fwd_l];

  // Return path.
  assign bwd_l = trrc_pkg::sub26(trrc_pkg::INV_LEFT[s1_refl], s1_pos.left);
  assign bwd_m = trrc_pkg::sub26(trrc_pkg::INV_MIDDLE[bwd_l], s1_pos.middle);
  assign bwd_r = trrc_pkg::sub26(trrc_pkg::INV_RIGHT[bwd_m], s1_pos.right);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= !q_empty;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      s1_refl <= refl;
      s1_pos  <= q_data.pos;
    end
    if (s1_valid && out_free) begin
      letter_out <= bwd_r;
    end
  end

  `TRRC_ASSERT(back_s1_hold, (s1_valid && !out_free) |=> (s1_valid && $stable(s1_refl)), "stalled stage lost its letter")

endmodule

`default_nettype wire

@@ rtl/core/three_rotor_reflector_cipher.sv @@
`default_nettype none
// Three-rotor reflector cipher, one letter per cycle while pop keeps the result channel from stalling.
// Input channel (push/full): each transaction carries kind and letter_in. A letter
//   transaction (kind 0) steps the rotors and yields one enciphered letter; a reload
//   transaction (kind 1) loads the rotor positions from the start registers and
//   yields nothing.
// Result channel (empty/pop): letter_out holds the oldest result while empty is low;
//   pop takes it.
// Configuration: APB-style writes to left_start (0x0), middle_start (0x4) and
//   right_start (0x8); starts above 25 are folded mod 26 on reload. Write them only
//   while the block is idle.
// Flow: an accepted letter is written into the queue, then passes the forward stage
//   (forward pass and reflector) and then the return stage into letter_out.
//   Throughput: one transaction per cycle while full is low, set by the rotor step
//   recurrence in the front end.
// Reset: rotor positions, start registers, queue and output clear to zero/empty.
// Stall: when the receiver holds pop low, the output stage and the middle stage
//   hold, the queue fills and full rises once it reaches its depth.

module three_rotor_reflector_cipher #(
  parameter int QUEUE_DEPTH = trrc_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // input channel
  input  wire logic        push,
  output      logic        full,
  input  wire logic        kind,
  input  wire logic [4:0]  letter_in,
  // result channel
  output      logic        empty,
  input  wire logic        pop,
  output      logic [4:0]  letter_out
);

  trrc_pkg::pos_t start;
  logic [1:0]     reg_idx;
  logic           cfg_wr;
  logic           q_wr;
  trrc_pkg::job_t q_wdata;
  logic           q_full;
  logic           q_rd;
  trrc_pkg::job_t q_rdata;
  logic           q_empty;

  // Register file: word index from the address; pready is tied high, so there are no wait states.
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        trrc_pkg::REG_LEFT_START:   start.left   <= pwdata[4:0];
        trrc_pkg::REG_MIDDLE_START: start.middle <= pwdata[4:0];
        trrc_pkg::REG_RIGHT_START:  start.right  <= pwdata[4:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      trrc_pkg::REG_LEFT_START:   prdata = {27'd0, start.left};
      trrc_pkg::REG_MIDDLE_START: prdata = {27'd0, start.middle};
      trrc_pkg::REG_RIGHT_START:  prdata = {27'd0, start.right};
      default:                    prdata = '0;
    endcase
  end

  // Front end: accept, step or reload the rotors, tag each letter with its positions.
  trrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .push      (push),
    .kind      (kind),
    .letter_in (letter_in),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_wdata)
  );

  assign full = q_full;

  // Decoupling queue between the stepping front end and the lookup back end.
  trrc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back end: forward pass and reflector, then return pass into the output register.
  trrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .letter_out (letter_out)
  );

endmodule

`default_nettype wire
